// ----- sv/gsl_pkg.sv -----
// Shared types, register indexes and constants of the gimbal start-up and lock sequencer.
package gsl_pkg;

   // Configuration register indexes, in the order of the register map.
   localparam logic [2:0] REG_SEQUENCE_ENABLE = 3'd0;
   localparam logic [2:0] REG_MAX_ANGLE_ROLL  = 3'd1;
   localparam logic [2:0] REG_MAX_ANGLE_PITCH = 3'd2;
   localparam logic [2:0] REG_MAX_RATE_ROLL   = 3'd3;
   localparam logic [2:0] REG_MAX_RATE_PITCH  = 3'd4;
   localparam logic [2:0] REG_DAMPING_ROLL    = 3'd5;
   localparam logic [2:0] REG_DAMPING_PITCH   = 3'd6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Sequencer modes.
   localparam logic [2:0] MODE_WAIT       = 3'd0;
   localparam logic [2:0] MODE_ROLL_RIGHT = 3'd1;
   localparam logic [2:0] MODE_ROLL_LEFT  = 3'd2;
   localparam logic [2:0] MODE_PITCH_UP   = 3'd3;
   localparam logic [2:0] MODE_PITCH_DOWN = 3'd4;
   localparam logic [2:0] MODE_RUNNING    = 3'd5;

   // Timing in microseconds and the test speed in 1/256 deg/s (100 deg/s).
   localparam logic [31:0]        POWERUP_US = 32'd7000000;
   localparam logic [31:0]        TEST_US    = 32'd1000000;
   localparam logic signed [19:0] TEST_SPEED = 20'sd25600;

   typedef struct packed {
      logic        sequence_enable;
      logic [14:0] max_angle_roll;
      logic [14:0] max_angle_pitch;
      logic [10:0] max_rate_roll;
      logic [10:0] max_rate_pitch;
      logic [15:0] damping_roll;
      logic [15:0] damping_pitch;
   } cfg_type;

   // Decision of the sequencer for one update.
   typedef struct packed {
      logic [2:0]         mode;
      logic               drive_locked;
      logic               speed_valid;
      logic               phase_valid;
      logic               use_scaled;
      logic signed [19:0] test_roll;
      logic signed [19:0] test_pitch;
   } cmd_type;

endpackage

// ----- sv/gsl_csr.sv -----
// Configuration register file of the gimbal start-up and lock sequencer.
module gsl_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [gsl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gsl_pkg::CSR_DATA_W-1:0]  csr_data,
   output gsl_pkg::cfg_type              cfg
);
   import gsl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_SEQUENCE_ENABLE: cfg_in.sequence_enable = csr_data[0];
            REG_MAX_ANGLE_ROLL:  cfg_in.max_angle_roll  = csr_data[14:0];
            REG_MAX_ANGLE_PITCH: cfg_in.max_angle_pitch = csr_data[14:0];
            REG_MAX_RATE_ROLL:   cfg_in.max_rate_roll   = csr_data[10:0];
            REG_MAX_RATE_PITCH:  cfg_in.max_rate_pitch  = csr_data[10:0];
            REG_DAMPING_ROLL:    cfg_in.damping_roll    = csr_data;
            REG_DAMPING_PITCH:   cfg_in.damping_pitch   = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sequence_enable <= 1'b0;
         cfg_ff.max_angle_roll  <= 15'd4500;
         cfg_ff.max_angle_pitch <= 15'd4500;
         cfg_ff.max_rate_roll   <= 11'd100;
         cfg_ff.max_rate_pitch  <= 11'd100;
         cfg_ff.damping_roll    <= 16'd0;
         cfg_ff.damping_pitch   <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/gsl_math.sv -----
// Tilt limit test, speed scaling and gyro damping products of the sequencer.
module gsl_math (
   input  gsl_pkg::cfg_type    cfg,
   input  logic signed [15:0]  camera_roll,
   input  logic signed [15:0]  camera_pitch,
   input  logic signed [15:0]  camera_declination,
   input  logic signed [15:0]  demand_roll,
   input  logic signed [15:0]  demand_pitch,
   input  logic signed [15:0]  gyro_roll,
   input  logic signed [15:0]  gyro_pitch,
   output logic                lock_hit,
   output logic signed [19:0]  speed_roll,
   output logic signed [19:0]  speed_pitch,
   output logic signed [27:0]  phase_roll,
   output logic signed [27:0]  phase_pitch
);
   import gsl_pkg::*;

   logic signed [16:0] roll_ext;
   logic signed [16:0] pitch_ext;
   logic signed [16:0] decl_ext;
   logic signed [16:0] err_pitch;
   logic [16:0]        abs_roll;
   logic [16:0]        abs_pitch;
   logic [16:0]        abs_err;

   logic signed [27:0] prod_speed_roll;
   logic signed [27:0] prod_speed_pitch;
   logic signed [27:0] sum_speed_roll;
   logic signed [27:0] sum_speed_pitch;
   logic signed [32:0] prod_phase_roll;
   logic signed [32:0] prod_phase_pitch;
   logic signed [32:0] sum_phase_roll;
   logic signed [32:0] sum_phase_pitch;

   // Limit test on magnitudes; the error term is one bit wider than the angles.
   assign roll_ext  = 17'(camera_roll);
   assign pitch_ext = 17'(camera_pitch);
   assign decl_ext  = 17'(camera_declination);
   assign err_pitch = pitch_ext - decl_ext;

   assign abs_roll  = roll_ext[16]  ? 17'(-roll_ext)  : 17'(roll_ext);
   assign abs_pitch = pitch_ext[16] ? 17'(-pitch_ext) : 17'(pitch_ext);
   assign abs_err   = err_pitch[16] ? 17'(-err_pitch) : 17'(err_pitch);

   assign lock_hit = (abs_roll  > {2'b00, cfg.max_angle_roll})
                  || (abs_pitch > {2'b00, cfg.max_angle_pitch})
                  || (abs_err   > {2'b00, cfg.max_angle_pitch});

   // Speed: demand (Q1.15) times deg/s, rounded half up to 1/256 deg/s.
   assign prod_speed_roll  = 28'(demand_roll)  * 28'($signed({1'b0, cfg.max_rate_roll}));
   assign prod_speed_pitch = 28'(demand_pitch) * 28'($signed({1'b0, cfg.max_rate_pitch}));
   assign sum_speed_roll   = prod_speed_roll  + 28'sd64;
   assign sum_speed_pitch  = prod_speed_pitch + 28'sd64;
   assign speed_roll       = sum_speed_roll[26:7];
   assign speed_pitch      = sum_speed_pitch[26:7];

   // Phase lag: negated gyro times Q8.8 damping, rounded half up to 1/256 deg.
   assign prod_phase_roll  = 33'(gyro_roll)  * 33'($signed({1'b0, cfg.damping_roll}));
   assign prod_phase_pitch = 33'(gyro_pitch) * 33'($signed({1'b0, cfg.damping_pitch}));
   assign sum_phase_roll   = 33'sd8 - prod_phase_roll;
   assign sum_phase_pitch  = 33'sd8 - prod_phase_pitch;
   assign phase_roll       = sum_phase_roll[31:4];
   assign phase_pitch      = sum_phase_pitch[31:4];

endmodule

// ----- sv/gsl_seq.sv -----
// Mode sequencer: power-up wait, four test moves if the sequence is enabled, then running with tilt lock.
module gsl_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic              sequence_enable,
   input  logic [31:0]       time_us,
   input  logic              lock_hit,
   output gsl_pkg::cmd_type  cmd
);
   import gsl_pkg::*;

   logic [2:0]  mode_ff;
   logic [2:0]  mode_in;
   logic [31:0] start_ff;
   logic [31:0] start_in;
   logic        lock_ff;
   logic        lock_in;
   logic [31:0] elapsed;

   // Elapsed time wraps with the timestamp.
   assign elapsed = time_us - start_ff;

   always_comb begin
      mode_in        = mode_ff;
      start_in       = start_ff;
      lock_in        = lock_ff;
      cmd.speed_valid = 1'b0;
      cmd.phase_valid = 1'b0;
      cmd.use_scaled  = 1'b0;
      cmd.test_roll   = '0;
      cmd.test_pitch  = '0;
      case (mode_ff)
         MODE_WAIT: begin
            if (elapsed > POWERUP_US) begin
               mode_in         = sequence_enable ? MODE_ROLL_RIGHT : MODE_RUNNING;
               start_in        = time_us;
               lock_in         = 1'b0;
               cmd.phase_valid = 1'b1;
            end
         end
         MODE_ROLL_RIGHT, MODE_ROLL_LEFT, MODE_PITCH_UP, MODE_PITCH_DOWN: begin
            if (elapsed > TEST_US) begin
               mode_in  = mode_ff + 3'd1;
               start_in = time_us;
            end else begin
               cmd.speed_valid = 1'b1;
               if (mode_ff == MODE_ROLL_RIGHT) begin
                  cmd.test_roll = TEST_SPEED;
               end else if (mode_ff == MODE_ROLL_LEFT) begin
                  cmd.test_roll = -TEST_SPEED;
               end else if (mode_ff == MODE_PITCH_UP) begin
                  cmd.test_pitch = TEST_SPEED;
               end else begin
                  cmd.test_pitch = -TEST_SPEED;
               end
            end
         end
         default: begin
            // Running; the unused codes behave the same way.
            mode_in         = MODE_RUNNING;
            lock_in         = lock_hit;
            cmd.speed_valid = !lock_hit;
            cmd.phase_valid = !lock_hit;
            cmd.use_scaled  = !lock_hit;
         end
      endcase
      cmd.mode         = mode_in;
      cmd.drive_locked = lock_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_WAIT;
         start_ff <= '0;
         lock_ff  <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         lock_ff  <= lock_in;
      end
   end

endmodule

// ----- sv/gimbal_startup_and_lock_sequencer.sv -----
// Top level of the gimbal start-up and lock sequencer.
//
//   channel  ports   direction  handshake        carries
//   request  req_*   in         valid / stall    one control update
//   response rsp_*   out        valid / stall    one command result per update
//   config   csr_*   in         write enable     one register write
//
// An update is taken into an input register, its command is worked out from
// there and written to the result register, which drives the response; a
// stalled response can keep the update waiting in the input register. One
// update per cycle is sustained while the response is not stalled.
// The rate is set by the single pass from input register to result register,
// where the mode sequencer state is updated as the result is written.
// Reset is synchronous and active high; it clears the mode, the mode start
// time, the lock flag, both valid flags and loads the register defaults.
// A stalled response holds the result register and any item in the input
// register; the request side is stalled only while the input register holds
// an item that cannot move on.
module gimbal_startup_and_lock_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [31:0]                     req_time_us,
   input  logic signed [15:0]              req_camera_roll,
   input  logic signed [15:0]              req_camera_pitch,
   input  logic signed [15:0]              req_camera_declination,
   input  logic signed [15:0]              req_demand_roll,
   input  logic signed [15:0]              req_demand_pitch,
   input  logic signed [15:0]              req_gyro_roll,
   input  logic signed [15:0]              req_gyro_pitch,
   // Response channel.
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_mode,
   output logic                            rsp_drive_locked,
   output logic                            rsp_speed_valid,
   output logic signed [19:0]              rsp_speed_roll,
   output logic signed [19:0]              rsp_speed_pitch,
   output logic                            rsp_phase_valid,
   output logic signed [27:0]              rsp_phase_roll,
   output logic signed [27:0]              rsp_phase_pitch,
   // Configuration port.
   input  logic                            csr_write,
   input  logic [gsl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gsl_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gsl_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   // Input register.
   logic               in_valid_ff;
   logic               in_valid_in;
   logic [31:0]        in_time_ff;
   logic signed [15:0] in_cam_roll_ff;
   logic signed [15:0] in_cam_pitch_ff;
   logic signed [15:0] in_cam_decl_ff;
   logic signed [15:0] in_dem_roll_ff;
   logic signed [15:0] in_dem_pitch_ff;
   logic signed [15:0] in_gyro_roll_ff;
   logic signed [15:0] in_gyro_pitch_ff;

   // Result register.
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [2:0]         out_mode_ff;
   logic               out_locked_ff;
   logic               out_speed_valid_ff;
   logic signed [19:0] out_speed_roll_ff;
   logic signed [19:0] out_speed_pitch_ff;
   logic               out_phase_valid_ff;
   logic signed [27:0] out_phase_roll_ff;
   logic signed [27:0] out_phase_pitch_ff;
   logic signed [19:0] out_speed_roll_in;
   logic signed [19:0] out_speed_pitch_in;
   logic signed [27:0] out_phase_roll_in;
   logic signed [27:0] out_phase_pitch_in;

   logic               advance;
   logic               fire;
   logic               take;
   logic               lock_hit;
   logic signed [19:0] speed_roll;
   logic signed [19:0] speed_pitch;
   logic signed [27:0] phase_roll;
   logic signed [27:0] phase_pitch;

   // The result register can take a new result when it is empty or being drained.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   gsl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gsl_math u_math (
      .cfg                (cfg),
      .camera_roll        (in_cam_roll_ff),
      .camera_pitch       (in_cam_pitch_ff),
      .camera_declination (in_cam_decl_ff),
      .demand_roll        (in_dem_roll_ff),
      .demand_pitch       (in_dem_pitch_ff),
      .gyro_roll          (in_gyro_roll_ff),
      .gyro_pitch         (in_gyro_pitch_ff),
      .lock_hit           (lock_hit),
      .speed_roll         (speed_roll),
      .speed_pitch        (speed_pitch),
      .phase_roll         (phase_roll),
      .phase_pitch        (phase_pitch)
   );

   // The sequencer state moves on only when the result is written.
   gsl_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .sequence_enable (cfg.sequence_enable),
      .time_us         (in_time_ff),
      .lock_hit        (lock_hit),
      .cmd             (cmd)
   );

   // Speeds are either the fixed test speeds or the scaled demands; phase lags
   // are zero when leaving the power-up wait and the damped gyro rates when running.
   always_comb begin
      out_speed_roll_in  = '0;
      out_speed_pitch_in = '0;
      out_phase_roll_in  = '0;
      out_phase_pitch_in = '0;
      if (cmd.speed_valid) begin
         out_speed_roll_in  = cmd.use_scaled ? speed_roll  : cmd.test_roll;
         out_speed_pitch_in = cmd.use_scaled ? speed_pitch : cmd.test_pitch;
      end
      if (cmd.phase_valid && cmd.use_scaled) begin
         out_phase_roll_in  = phase_roll;
         out_phase_pitch_in = phase_pitch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_time_ff       <= req_time_us;
         in_cam_roll_ff   <= req_camera_roll;
         in_cam_pitch_ff  <= req_camera_pitch;
         in_cam_decl_ff   <= req_camera_declination;
         in_dem_roll_ff   <= req_demand_roll;
         in_dem_pitch_ff  <= req_demand_pitch;
         in_gyro_roll_ff  <= req_gyro_roll;
         in_gyro_pitch_ff <= req_gyro_pitch;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_mode_ff        <= cmd.mode;
         out_locked_ff      <= cmd.drive_locked;
         out_speed_valid_ff <= cmd.speed_valid;
         out_speed_roll_ff  <= out_speed_roll_in;
         out_speed_pitch_ff <= out_speed_pitch_in;
         out_phase_valid_ff <= cmd.phase_valid;
         out_phase_roll_ff  <= out_phase_roll_in;
         out_phase_pitch_ff <= out_phase_pitch_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_mode         = out_mode_ff;
   assign rsp_drive_locked = out_locked_ff;
   assign rsp_speed_valid  = out_speed_valid_ff;
   assign rsp_speed_roll   = out_speed_roll_ff;
   assign rsp_speed_pitch  = out_speed_pitch_ff;
   assign rsp_phase_valid  = out_phase_valid_ff;
   assign rsp_phase_roll   = out_phase_roll_ff;
   assign rsp_phase_pitch  = out_phase_pitch_ff;

`ifndef SYNTHESIS
   // Speeds and phase lags are both commanded only while running unlocked.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_speed_valid && rsp_phase_valid
         |-> rsp_mode == MODE_RUNNING && !rsp_drive_locked)
      else $error("speed and phase commanded outside unlocked running");

   // A locked drive never comes with a command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_locked |-> !rsp_speed_valid && !rsp_phase_valid)
      else $error("command issued while the drive is locked");

   // The lock can only be set in running mode.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode != MODE_RUNNING |-> !rsp_drive_locked)
      else $error("drive locked outside running mode");

   // The request side is held off only while the input register is full and blocked.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled without a blocked input register");
`endif

endmodule

// ----- verif/tb_gimbal_startup_and_lock_sequencer.sv -----
// Self-checking testbench of the gimbal start-up and lock sequencer.
module tb_gimbal_startup_and_lock_sequencer;
   import gsl_pkg::*;

   // A run with no transfer for this many cycles is hung. The longest quiet
   // stretch of a correct run is the deliberate response hold.
   localparam int WATCHDOG_LIMIT = 5000;
   // The block answers through its input and result registers; this covers it.
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 300;

   typedef enum {SET_MINIMUM, SET_MAXIMUM, SET_FULL_WIDTH, SET_IN_RANGE} settings_kind_type;

   // One control update as it crosses the request channel.
   typedef struct {
      logic [31:0]        time_us;
      logic signed [15:0] camera_roll;
      logic signed [15:0] camera_pitch;
      logic signed [15:0] camera_declination;
      logic signed [15:0] demand_roll;
      logic signed [15:0] demand_pitch;
      logic signed [15:0] gyro_roll;
      logic signed [15:0] gyro_pitch;
   } update_type;

   // One command as it crosses the response channel.
   typedef struct {
      logic [2:0]         mode;
      logic               drive_locked;
      logic               speed_valid;
      logic signed [19:0] speed_roll;
      logic signed [19:0] speed_pitch;
      logic               phase_valid;
      logic signed [27:0] phase_roll;
      logic signed [27:0] phase_pitch;
   } command_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [31:0]            req_time_us = '0;
   logic signed [15:0]     req_camera_roll = '0;
   logic signed [15:0]     req_camera_pitch = '0;
   logic signed [15:0]     req_camera_declination = '0;
   logic signed [15:0]     req_demand_roll = '0;
   logic signed [15:0]     req_demand_pitch = '0;
   logic signed [15:0]     req_gyro_roll = '0;
   logic signed [15:0]     req_gyro_pitch = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [2:0]             rsp_mode;
   logic                   rsp_drive_locked;
   logic                   rsp_speed_valid;
   logic signed [19:0]     rsp_speed_roll;
   logic signed [19:0]     rsp_speed_pitch;
   logic                   rsp_phase_valid;
   logic signed [27:0]     rsp_phase_roll;
   logic signed [27:0]     rsp_phase_pitch;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Sequencer state and register copy as the predictor sees them.
   cfg_type     model_cfg;
   logic [2:0]  seq_mode;
   logic [31:0] seq_start_us;
   logic        seq_lock;
   // Register values last written, used to shape the stimulus.
   cfg_type     drive_cfg;

   command_type pending_commands[$];
   int          mismatches = 0;
   int          accepted_updates = 0;
   int          checked_commands = 0;
   int          quiet_cycles = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          hold_request = 0;
   int          hold_left = 0;

   gimbal_startup_and_lock_sequencer dut (.*);

   always #4 clock = ~clock;

   function automatic longint magnitude(input longint x);
      return (x < 0) ? -x : x;
   endfunction

   // Demand (Q1.15) times deg/s in 1/256 deg/s: divide by 128, halves upward.
   function automatic logic signed [19:0] scaled_speed(input logic signed [15:0] demand,
                                                       input logic [10:0] rate);
      longint product;
      product = longint'(demand) * longint'(rate);
      return 20'((product + 64) >>> 7);
   endfunction

   // Negated gyro (1/16 deg/s) times damping (Q8.8) in 1/256 deg, halves upward.
   function automatic logic signed [27:0] damped_phase(input logic signed [15:0] gyro,
                                                       input logic [15:0] damping);
      longint product;
      product = -(longint'(gyro) * longint'(damping));
      return 28'((product + 8) >>> 4);
   endfunction

   // Advances the sequencer copy by one update and returns the command it gives.
   function automatic command_type predict_command(input update_type u);
      command_type c;
      logic [31:0] elapsed;
      logic        over;
      c = '{default: '0};
      // Elapsed time wraps with the 32-bit timestamp.
      elapsed = u.time_us - seq_start_us;
      if (seq_mode == MODE_WAIT) begin
         if (elapsed > POWERUP_US) begin
            seq_mode = model_cfg.sequence_enable ? MODE_ROLL_RIGHT : MODE_RUNNING;
            seq_start_us = u.time_us;
            seq_lock = 1'b0;
            c.phase_valid = 1'b1;
         end
      end else if (seq_mode >= MODE_ROLL_RIGHT && seq_mode <= MODE_PITCH_DOWN) begin
         if (elapsed > TEST_US) begin
            // The step that ends a test move commands nothing.
            seq_mode = seq_mode + 3'd1;
            seq_start_us = u.time_us;
         end else begin
            c.speed_valid = 1'b1;
            case (seq_mode)
               MODE_ROLL_RIGHT: c.speed_roll = TEST_SPEED;
               MODE_ROLL_LEFT:  c.speed_roll = -TEST_SPEED;
               MODE_PITCH_UP:   c.speed_pitch = TEST_SPEED;
               default:         c.speed_pitch = -TEST_SPEED;
            endcase
         end
      end else begin
         over = magnitude(longint'(u.camera_roll)) > longint'(model_cfg.max_angle_roll)
             || magnitude(longint'(u.camera_pitch)) > longint'(model_cfg.max_angle_pitch)
             || magnitude(longint'(u.camera_pitch) - longint'(u.camera_declination))
                > longint'(model_cfg.max_angle_pitch);
         seq_mode = MODE_RUNNING;
         seq_lock = over;
         if (!over) begin
            c.speed_valid = 1'b1;
            c.phase_valid = 1'b1;
            c.speed_roll = scaled_speed(u.demand_roll, model_cfg.max_rate_roll);
            c.speed_pitch = scaled_speed(u.demand_pitch, model_cfg.max_rate_pitch);
            c.phase_roll = damped_phase(u.gyro_roll, model_cfg.damping_roll);
            c.phase_pitch = damped_phase(u.gyro_pitch, model_cfg.damping_pitch);
         end
      end
      c.mode = seq_mode;
      c.drive_locked = seq_lock;
      return c;
   endfunction

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Follows every transfer on all three ports: register writes update the
   // register copy, request transfers queue a predicted command and response
   // transfers are checked against the oldest one.
   always @(posedge clock) begin : monitor
      update_type  u;
      command_type want;
      if (reset) begin
         model_cfg = '{sequence_enable: 1'b0, max_angle_roll: 15'd4500,
                       max_angle_pitch: 15'd4500, max_rate_roll: 11'd100,
                       max_rate_pitch: 11'd100, damping_roll: 16'd0, damping_pitch: 16'd0};
         seq_mode = MODE_WAIT;
         seq_start_us = '0;
         seq_lock = 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_SEQUENCE_ENABLE: model_cfg.sequence_enable = csr_data[0];
               REG_MAX_ANGLE_ROLL:  model_cfg.max_angle_roll = csr_data[14:0];
               REG_MAX_ANGLE_PITCH: model_cfg.max_angle_pitch = csr_data[14:0];
               REG_MAX_RATE_ROLL:   model_cfg.max_rate_roll = csr_data[10:0];
               REG_MAX_RATE_PITCH:  model_cfg.max_rate_pitch = csr_data[10:0];
               REG_DAMPING_ROLL:    model_cfg.damping_roll = csr_data;
               REG_DAMPING_PITCH:   model_cfg.damping_pitch = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            u.time_us = req_time_us;
            u.camera_roll = req_camera_roll;
            u.camera_pitch = req_camera_pitch;
            u.camera_declination = req_camera_declination;
            u.demand_roll = req_demand_roll;
            u.demand_pitch = req_demand_pitch;
            u.gyro_roll = req_gyro_roll;
            u.gyro_pitch = req_gyro_pitch;
            pending_commands.push_back(predict_command(u));
            accepted_updates++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_commands.size() == 0) begin
               $display("%0t: response transfer with no command pending", $time);
               mismatches++;
            end else begin
               want = pending_commands.pop_front();
               checked_commands++;
               check_field("mode", want.mode, rsp_mode);
               check_field("drive_locked", want.drive_locked, rsp_drive_locked);
               check_field("speed_valid", want.speed_valid, rsp_speed_valid);
               check_field("speed_roll", want.speed_roll, rsp_speed_roll);
               check_field("speed_pitch", want.speed_pitch, rsp_speed_pitch);
               check_field("phase_valid", want.phase_valid, rsp_phase_valid);
               check_field("phase_roll", want.phase_roll, rsp_phase_roll);
               check_field("phase_pitch", want.phase_pitch, rsp_phase_pitch);
            end
         end
      end
   end

   // Response side: random stalls, or one long hold when a test asks for it.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_request - 1;
         hold_request <= 0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("[gimbal_startup_and_lock_sequencer] ERROR");
         $finish;
      end
   end

   // Offers one update, idling first at random, and returns at its transfer.
   task automatic send_update(input update_type u);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_time_us <= u.time_us;
      req_camera_roll <= u.camera_roll;
      req_camera_pitch <= u.camera_pitch;
      req_camera_declination <= u.camera_declination;
      req_demand_roll <= u.demand_roll;
      req_demand_pitch <= u.demand_pitch;
      req_gyro_roll <= u.gyro_roll;
      req_gyro_pitch <= u.gyro_pitch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stops offering and waits until every predicted command has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_commands.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_INDEX_W-1:0] index,
                          input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
   endtask

   // Writes all seven registers in back-to-back cycles; the block must be idle.
   task automatic write_settings(input cfg_type s);
      drive_cfg = s;
      csr_put(REG_SEQUENCE_ENABLE, CSR_DATA_W'(s.sequence_enable));
      csr_put(REG_MAX_ANGLE_ROLL, CSR_DATA_W'(s.max_angle_roll));
      csr_put(REG_MAX_ANGLE_PITCH, CSR_DATA_W'(s.max_angle_pitch));
      csr_put(REG_MAX_RATE_ROLL, CSR_DATA_W'(s.max_rate_roll));
      csr_put(REG_MAX_RATE_PITCH, CSR_DATA_W'(s.max_rate_pitch));
      csr_put(REG_DAMPING_ROLL, s.damping_roll);
      csr_put(REG_DAMPING_PITCH, s.damping_pitch);
      csr_write <= 1'b0;
   endtask

   function automatic cfg_type pick_settings(input settings_kind_type kind);
      cfg_type s;
      s.sequence_enable = 1'($urandom_range(1));
      case (kind)
         SET_MINIMUM: begin
            s.max_angle_roll = '0;
            s.max_angle_pitch = '0;
            s.max_rate_roll = '0;
            s.max_rate_pitch = '0;
            s.damping_roll = '0;
            s.damping_pitch = '0;
         end
         SET_MAXIMUM: begin
            s.max_angle_roll = 15'd18000;
            s.max_angle_pitch = 15'd18000;
            s.max_rate_roll = 11'd2000;
            s.max_rate_pitch = 11'd2000;
            s.damping_roll = 16'hFFFF;
            s.damping_pitch = 16'hFFFF;
         end
         SET_FULL_WIDTH: begin
            // Values beyond the documented ranges are used as written.
            s.max_angle_roll = 15'($urandom);
            s.max_angle_pitch = 15'($urandom);
            s.max_rate_roll = 11'($urandom);
            s.max_rate_pitch = 11'($urandom);
            s.damping_roll = 16'($urandom);
            s.damping_pitch = 16'($urandom);
         end
         default: begin
            s.max_angle_roll = 15'($urandom_range(18000));
            s.max_angle_pitch = 15'($urandom_range(18000));
            s.max_rate_roll = 11'($urandom_range(2000));
            s.max_rate_pitch = 11'($urandom_range(2000));
            s.damping_roll = 16'($urandom);
            s.damping_pitch = 16'($urandom);
         end
      endcase
      return s;
   endfunction

   function automatic logic signed [15:0] pick_angle(input int lim);
      return 16'(int'($urandom_range(2 * lim)) - lim);
   endfunction

   // Most updates sit inside the tilt limits so that speeds and phase lags are
   // commanded; a quarter carry arbitrary angles and mostly lock the drive.
   function automatic update_type random_update();
      update_type u;
      int         lim_r;
      int         lim_p;
      lim_r = (drive_cfg.max_angle_roll > 18000) ? 18000 : int'(drive_cfg.max_angle_roll);
      lim_p = (drive_cfg.max_angle_pitch > 18000) ? 18000 : int'(drive_cfg.max_angle_pitch);
      u.time_us = $urandom;
      if ($urandom_range(3) == 0) begin
         u.camera_roll = 16'($urandom);
         u.camera_pitch = 16'($urandom);
         u.camera_declination = 16'($urandom);
      end else begin
         u.camera_roll = pick_angle(lim_r);
         if ($urandom_range(7) == 0)
            u.camera_roll = 16'(($urandom_range(1) ? 1 : -1) * (lim_r + $urandom_range(1)));
         u.camera_pitch = pick_angle(lim_p / 2);
         u.camera_declination = u.camera_pitch + pick_angle(lim_p / 2);
      end
      u.demand_roll = 16'($urandom);
      u.demand_pitch = 16'($urandom);
      u.gyro_roll = 16'($urandom);
      u.gyro_pitch = 16'($urandom);
      return u;
   endfunction

   function automatic update_type uniform_update(input logic [31:0] stamp,
                                                 input logic signed [15:0] v);
      update_type u;
      u = '{stamp, v, v, v, v, v, v, v};
      return u;
   endfunction

   task automatic send_angles(input logic signed [15:0] roll, input logic signed [15:0] pitch,
                              input logic signed [15:0] declination);
      update_type u;
      u = random_update();
      u.camera_roll = roll;
      u.camera_pitch = pitch;
      u.camera_declination = declination;
      send_update(u);
   endtask

   // Power-up wait: not over at zero elapsed time nor at exactly 7 s, over well
   // past it. The leaving update uses a timestamp close to the 32-bit wrap.
   task automatic test_power_up_wait();
      cfg_type s;
      s = pick_settings(SET_MINIMUM);
      s.sequence_enable = 1'b1;
      s.max_angle_roll = 15'd4500;
      s.max_angle_pitch = 15'd4500;
      s.max_rate_roll = 11'd100;
      s.max_rate_pitch = 11'd100;
      write_settings(s);
      send_update(uniform_update(32'd0, -16'sd32768));
      send_update(uniform_update(POWERUP_US, 16'sd32767));
      send_update(uniform_update(32'd1, 16'sd0));
      send_update(uniform_update(32'hFFFF_FF00, -16'sd1));
   endtask

   // The four test moves, each offered once inside its second and once past it.
   // The first move crosses the timestamp wrap and hits the exact 1 s boundary.
   task automatic test_calibration_moves();
      update_type  u;
      logic [31:0] start_us;
      start_us = 32'hFFFF_FF00;
      for (int k = 0; k < 4; k++) begin
         u = random_update();
         u.time_us = start_us + $urandom_range(TEST_US);
         send_update(u);
         if (k == 0) begin
            u = random_update();
            u.time_us = start_us + TEST_US;
            send_update(u);
         end
         u = random_update();
         u.time_us = start_us + TEST_US + 32'd1;
         send_update(u);
         start_us = u.time_us;
      end
   endtask

   // Tilt limits of 4500 on each side of the strict comparisons.
   task automatic test_lock_limits();
      send_angles(16'sd4500, 16'sd0, 16'sd0);
      send_angles(16'sd4501, 16'sd0, 16'sd0);
      send_angles(-16'sd4500, 16'sd0, 16'sd0);
      send_angles(-16'sd4501, 16'sd0, 16'sd0);
      send_angles(16'sd0, 16'sd4500, 16'sd0);
      send_angles(16'sd0, -16'sd4501, -16'sd4501);
      send_angles(16'sd0, 16'sd0, -16'sd4501);
      send_angles(16'sd0, -16'sd4000, 16'sd500);
      send_angles(-16'sd32768, 16'sd0, 16'sd0);
   endtask

   // Full-scale products, then the rounding of exact halves in both signs.
   task automatic test_fixed_point_rounding();
      cfg_type    s;
      update_type u;
      wait_idle();
      s = drive_cfg;
      s.max_angle_roll = 15'h7FFF;
      s.max_angle_pitch = 15'h7FFF;
      s.max_rate_roll = 11'h7FF;
      s.max_rate_pitch = 11'h7FF;
      s.damping_roll = 16'hFFFF;
      s.damping_pitch = 16'hFFFF;
      write_settings(s);
      u = uniform_update($urandom, -16'sd32768);
      u.camera_roll = 16'sd0;
      u.camera_pitch = 16'sd0;
      u.camera_declination = 16'sd0;
      send_update(u);
      u = uniform_update($urandom, 16'sd32767);
      send_update(u);
      wait_idle();
      s.max_rate_roll = 11'd64;
      s.max_rate_pitch = 11'd64;
      s.damping_roll = 16'd8;
      s.damping_pitch = 16'd8;
      write_settings(s);
      u = uniform_update($urandom, 16'sd1);
      send_update(u);
      u = uniform_update($urandom, -16'sd1);
      send_update(u);
   endtask

   task automatic test_random_traffic(input settings_kind_type kind, input int count,
                                      input int sender_idle, input int receiver_stall);
      wait_idle();
      write_settings(pick_settings(kind));
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      repeat (count) send_update(random_update());
   endtask

   // The response side holds off while updates keep coming, so the block fills
   // up and must stall its request side until the hold ends.
   task automatic test_backpressure_fill();
      wait_idle();
      write_settings(pick_settings(SET_IN_RANGE));
      idle_pct = 0;
      stall_pct = 0;
      hold_request <= HOLD_CYCLES;
      repeat (60) send_update(random_update());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_power_up_wait();
      test_calibration_moves();
      test_lock_limits();
      test_fixed_point_rounding();
      test_random_traffic(SET_IN_RANGE, 180, 0, 0);
      test_random_traffic(SET_MAXIMUM, 170, 81, 0);
      test_random_traffic(SET_FULL_WIDTH, 170, 0, 81);
      test_random_traffic(SET_IN_RANGE, 170, 37, 37);
      test_random_traffic(SET_MINIMUM, 30, 37, 37);
      test_backpressure_fill();
      wait_idle();
      $display("Covered the power-up wait, all four test moves across the timestamp wrap,");
      $display("lock limits, rounding and %0d updates (%0d commands checked) under stalls.",
               accepted_updates, checked_commands);
      if (mismatches == 0)
         $display("[gimbal_startup_and_lock_sequencer] OK");
      else
         $display("[gimbal_startup_and_lock_sequencer] ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/gsl_pkg.sv
sv/gsl_csr.sv
sv/gsl_math.sv
sv/gsl_seq.sv
sv/gimbal_startup_and_lock_sequencer.sv
verif/tb_gimbal_startup_and_lock_sequencer.sv
